>>> hw/rtl/ndsf_pkg.sv
// Shared types, codes and character tables of the null-data script formatter.
package ndsf_pkg;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // Command kinds queued from the parser to the text generator
  localparam logic [2:0] KIND_NONE  = 3'd0;  // no characters, status only
  localparam logic [2:0] KIND_HEAD  = 3'd1;  // opening keyword of the text
  localparam logic [2:0] KIND_ZERO  = 3'd2;  // " 0"
  localparam logic [2:0] KIND_PFX   = 3'd3;  // " 0x"
  localparam logic [2:0] KIND_NEG   = 3'd4;  // " -1"
  localparam logic [2:0] KIND_SMALL = 3'd5;  // " 1" .. " 16"
  localparam logic [2:0] KIND_HEX   = 3'd6;  // two hex digits of one data byte

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_RETURN  = 3'd1;
  localparam logic [2:0] ST_TOO_LONG    = 3'd2;
  localparam logic [2:0] ST_BAD_OPCODE  = 3'd3;
  localparam logic [2:0] ST_NONMINIMAL  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED   = 3'd5;
  localparam logic [2:0] ST_TOO_MANY    = 3'd6;

  localparam logic [7:0] OPC_RETURN    = 8'h6a;
  localparam logic [7:0] OPC_PUSHDATA1 = 8'h4c;
  localparam logic [7:0] OPC_1NEGATE   = 8'h4f;
  localparam logic [7:0] OPC_1         = 8'h51;
  localparam logic [7:0] OPC_16        = 8'h60;
  localparam logic [7:0] MAX_DIRECT    = 8'd75;
  localparam logic [7:0] NEG_ONE_BYTE  = 8'h81;
  localparam logic [7:0] SMALL_BASE    = 8'h50;

  localparam logic [0:0] CFG_MAX_BYTES  = 1'b0;
  localparam logic [0:0] CFG_MAX_PUSHES = 1'b1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] val;
    logic       has_status;
    logic [2:0] status;
    logic [7:0] length;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

  function automatic logic [7:0] head_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "O";
      4'd1:    c = "P";
      4'd2:    c = "_";
      4'd3:    c = "R";
      4'd4:    c = "E";
      4'd5:    c = "T";
      4'd6:    c = "U";
      4'd7:    c = "R";
      default: c = "N";
    endcase
    return c;
  endfunction

  function automatic logic [3:0] char_count(input logic [2:0] kind, input logic [7:0] val);
    logic [3:0] n;
    case (kind)
      KIND_HEAD:  n = 4'd9;
      KIND_ZERO:  n = 4'd2;
      KIND_PFX:   n = 4'd3;
      KIND_NEG:   n = 4'd3;
      KIND_SMALL: n = ((val - SMALL_BASE) >= 8'd10) ? 4'd3 : 4'd2;
      KIND_HEX:   n = 4'd2;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] cmd_char(input logic [2:0] kind, input logic [7:0] val,
                                          input logic [3:0] idx);
    logic [7:0] c;
    logic [7:0] v;
    v = val - SMALL_BASE;
    c = 8'h20;
    case (kind)
      KIND_HEAD: c = head_char(idx);
      KIND_ZERO: c = (idx == 4'd0) ? 8'h20 : "0";
      KIND_PFX: begin
        case (idx)
          4'd0:    c = 8'h20;
          4'd1:    c = "0";
          default: c = "x";
        endcase
      end
      KIND_NEG: begin
        case (idx)
          4'd0:    c = 8'h20;
          4'd1:    c = "-";
          default: c = "1";
        endcase
      end
      KIND_SMALL: begin
        if (idx == 4'd0) begin
          c = 8'h20;
        end else if (v >= 8'd10) begin
          c = (idx == 4'd1) ? "1" : (8'h30 + (v - 8'd10));
        end else begin
          c = 8'h30 + v;
        end
      end
      KIND_HEX: c = (idx == 4'd0) ? hex_char(val[7:4]) : hex_char(val[3:0]);
      default:  c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/ndsf_in_if.sv
// Input byte channel of the formatter.
interface ndsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       last_byte;

  modport source(output valid, output script_byte, output last_byte, input ready);
  modport sink(input valid, input script_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/ndsf_out_if.sv
// Result channel of the formatter: text characters and the final status.
interface ndsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       status_valid;
  logic [2:0] status;
  logic [7:0] text_length;
  logic       run_last;

  modport source(output valid, output out_char, output char_valid, output status_valid,
                 output status, output text_length, output run_last, input ready);
  modport sink(input valid, input out_char, input char_valid, input status_valid,
               input status, input text_length, input run_last, output ready);
endinterface

>>> hw/rtl/ndsf_cfg_if.sv
// Configuration write channel of the formatter.
interface ndsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/ndsf_front.sv
// Script parser: checks each byte, tracks push state and queues at most one text command per byte.
module ndsf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        max_script_bytes,
  input  logic [3:0]        max_push_count,
  ndsf_in_if.sink           byte_in,
  input  logic              q_full,
  output logic              q_push,
  output ndsf_pkg::cmd_t    q_cmd
);

  localparam logic [1:0] PH_RETURN = 2'd0;
  localparam logic [1:0] PH_OPCODE = 2'd1;
  localparam logic [1:0] PH_LENGTH = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  logic [1:0] phase, phase_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] data_remaining, data_remaining_next;
  logic       single_byte_push, single_byte_push_next;
  logic [3:0] push_count, push_count_next;
  logic [2:0] error_code, error_code_next;
  logic [7:0] chars_emitted, chars_emitted_next;
  logic       accept;
  logic [2:0] kind;
  logic [8:0] chars_sum;

  assign byte_in.ready = !q_full;
  assign accept        = byte_in.valid && !q_full;

  always_comb begin
    logic [7:0] b;
    logic       over;
    logic [7:0] dr;
    b = byte_in.script_byte;
    over = byte_count >= max_script_bytes;
    phase_next            = phase;
    data_remaining_next   = data_remaining;
    single_byte_push_next = single_byte_push;
    push_count_next       = push_count;
    error_code_next       = error_code;
    kind                  = ndsf_pkg::KIND_NONE;
    dr                    = data_remaining;
    byte_count_next = (byte_count != 8'hff) ? byte_count + 8'd1 : byte_count;

    if (phase == PH_RETURN) begin
      phase_next = PH_OPCODE;
      if (b != ndsf_pkg::OPC_RETURN) begin
        error_code_next = ndsf_pkg::ST_NOT_RETURN;
      end else if (over) begin
        error_code_next = ndsf_pkg::ST_TOO_LONG;
      end else begin
        kind = ndsf_pkg::KIND_HEAD;
      end
    end else begin
      if (over && error_code != ndsf_pkg::ST_NOT_RETURN) begin
        error_code_next = ndsf_pkg::ST_TOO_LONG;
      end
      if (error_code_next == ndsf_pkg::ST_OK) begin
        case (phase)
          PH_OPCODE: begin
            if (push_count >= max_push_count) begin
              error_code_next = ndsf_pkg::ST_TOO_MANY;
            end else if (b == 8'd0) begin
              kind = ndsf_pkg::KIND_ZERO;
              push_count_next = push_count + 4'd1;
            end else if (b <= ndsf_pkg::MAX_DIRECT || b == ndsf_pkg::OPC_PUSHDATA1) begin
              kind = ndsf_pkg::KIND_PFX;
              if (b == ndsf_pkg::OPC_PUSHDATA1) begin
                phase_next = PH_LENGTH;
              end else begin
                data_remaining_next   = b;
                single_byte_push_next = (b == 8'd1);
                phase_next            = PH_DATA;
              end
            end else if (b == ndsf_pkg::OPC_1NEGATE) begin
              kind = ndsf_pkg::KIND_NEG;
              push_count_next = push_count + 4'd1;
            end else if (b >= ndsf_pkg::OPC_1 && b <= ndsf_pkg::OPC_16) begin
              kind = ndsf_pkg::KIND_SMALL;
              push_count_next = push_count + 4'd1;
            end else begin
              error_code_next = ndsf_pkg::ST_BAD_OPCODE;
            end
          end
          PH_LENGTH: begin
            if (b <= ndsf_pkg::MAX_DIRECT) begin
              error_code_next = ndsf_pkg::ST_NONMINIMAL;
            end else begin
              data_remaining_next   = b;
              single_byte_push_next = 1'b0;
              phase_next            = PH_DATA;
            end
          end
          default: begin
            if (single_byte_push &&
                (b == ndsf_pkg::NEG_ONE_BYTE || (b >= 8'd1 && b <= 8'd16))) begin
              error_code_next = ndsf_pkg::ST_NONMINIMAL;
            end else begin
              kind = ndsf_pkg::KIND_HEX;
              if (dr != 8'd0) begin
                dr = dr - 8'd1;
              end
              data_remaining_next = dr;
              if (dr == 8'd0) begin
                single_byte_push_next = 1'b0;
                push_count_next       = push_count + 4'd1;
                phase_next            = PH_OPCODE;
              end
            end
          end
        endcase
      end
    end

    // Saturate the text length at 255
    chars_sum = {1'b0, chars_emitted} + {5'd0, ndsf_pkg::char_count(kind, b)};
    chars_emitted_next = chars_sum[8] ? 8'hff : chars_sum[7:0];

    if (byte_in.last_byte && error_code_next == ndsf_pkg::ST_OK &&
        (phase_next == PH_LENGTH || phase_next == PH_DATA)) begin
      error_code_next = ndsf_pkg::ST_TRUNCATED;
    end

    q_cmd.kind       = kind;
    q_cmd.val        = b;
    q_cmd.has_status = byte_in.last_byte;
    q_cmd.status     = error_code_next;
    q_cmd.length     = (error_code_next == ndsf_pkg::ST_OK) ? chars_emitted_next : 8'd0;
    q_push = accept && (kind != ndsf_pkg::KIND_NONE || byte_in.last_byte);

    // Return to the start state after the final byte
    if (byte_in.last_byte) begin
      phase_next            = PH_RETURN;
      byte_count_next       = 8'd0;
      data_remaining_next   = 8'd0;
      single_byte_push_next = 1'b0;
      push_count_next       = 4'd0;
      error_code_next       = ndsf_pkg::ST_OK;
      chars_emitted_next    = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_RETURN;
      byte_count       <= 8'd0;
      data_remaining   <= 8'd0;
      single_byte_push <= 1'b0;
      push_count       <= 4'd0;
      error_code       <= ndsf_pkg::ST_OK;
      chars_emitted    <= 8'd0;
    end else if (accept) begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      data_remaining   <= data_remaining_next;
      single_byte_push <= single_byte_push_next;
      push_count       <= push_count_next;
      error_code       <= error_code_next;
      chars_emitted    <= chars_emitted_next;
    end
  end

endmodule

>>> hw/rtl/ndsf_queue.sv
// Short command queue between the parser and the text generator.
module ndsf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ndsf_pkg::cmd_t    push_cmd,
  output logic              full,
  output logic              head_valid,
  output ndsf_pkg::cmd_t    head_cmd,
  input  logic              pop
);

  ndsf_pkg::cmd_t            mem [ndsf_pkg::QDepth];
  logic [ndsf_pkg::QAw-1:0]  wr_ptr;
  logic [ndsf_pkg::QAw-1:0]  rd_ptr;
  logic [ndsf_pkg::QAw:0]    count;
  logic                      do_push;
  logic                      do_pop;

  assign full       = count == (ndsf_pkg::QAw+1)'(ndsf_pkg::QDepth);
  assign head_valid = count != '0;
  assign head_cmd   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/ndsf_back.sv
// Text generator: expands queued commands, one registered result per cycle unless stalled.
module ndsf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  ndsf_pkg::cmd_t    head_cmd,
  output logic              pop,
  ndsf_out_if.source        char_out
);

  logic [3:0] idx;
  logic [3:0] nchars;
  logic [3:0] total;
  logic       load;
  logic       at_end;

  assign nchars = ndsf_pkg::char_count(head_cmd.kind, head_cmd.val);
  assign total  = nchars + {3'd0, head_cmd.has_status};
  assign load   = head_valid && (!char_out.valid || char_out.ready);
  assign at_end = idx == total - 4'd1;
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_out.valid <= 1'b0;
      idx            <= 4'd0;
    end else if (load) begin
      char_out.valid <= 1'b1;
      idx            <= at_end ? 4'd0 : idx + 4'd1;
    end else if (char_out.ready) begin
      char_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_out.run_last <= at_end;
      if (idx < nchars) begin
        char_out.out_char     <= ndsf_pkg::cmd_char(head_cmd.kind, head_cmd.val, idx);
        char_out.char_valid   <= 1'b1;
        char_out.status_valid <= 1'b0;
        char_out.status       <= ndsf_pkg::ST_OK;
        char_out.text_length  <= 8'd0;
      end else begin
        char_out.out_char     <= 8'd0;
        char_out.char_valid   <= 1'b0;
        char_out.status_valid <= 1'b1;
        char_out.status       <= head_cmd.status;
        char_out.text_length  <= head_cmd.length;
      end
    end
  end

endmodule

>>> hw/rtl/null_data_script_formatter_core.sv
// Top level of the null-data script formatter: config registers, parser, queue, text generator.
// A byte transfer reaches its first result through the queue write, then the output register.
// Throughput: one script byte per cycle while the queue has room; each byte then causes results
//   (2 for a data byte, up to 9 for the return opcode, +1 for status).
// The 4-entry command queue absorbs the difference; the single-result output port sets the rate.
// Reset (rst, synchronous): parser state to the start of a script, queue and output emptied,
//   max_script_bytes to 83 and max_push_count to 5.
module null_data_script_formatter_core (
  input  logic       clk,
  input  logic       rst,
  ndsf_cfg_if.sink   cfg,
  ndsf_in_if.sink    byte_in,
  ndsf_out_if.source char_out
);

  logic [7:0]      max_script_bytes;
  logic [3:0]      max_push_count;
  logic            q_push;
  logic            q_full;
  logic            head_valid;
  logic            pop;
  ndsf_pkg::cmd_t  q_cmd;
  ndsf_pkg::cmd_t  head_cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_script_bytes <= 8'd83;
      max_push_count   <= 4'd5;
    end else if (cfg.valid) begin
      case (cfg.index)
        ndsf_pkg::CFG_MAX_BYTES:  max_script_bytes <= cfg.data;
        ndsf_pkg::CFG_MAX_PUSHES: max_push_count   <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  ndsf_front u_front (
    .clk              (clk),
    .rst              (rst),
    .max_script_bytes (max_script_bytes),
    .max_push_count   (max_push_count),
    .byte_in          (byte_in),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  ndsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  ndsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .char_out   (char_out)
  );

  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    char_out.valid && char_out.status_valid |-> !char_out.char_valid && char_out.run_last)
    else $error("status result not marked as last of its run");

  a_error_no_length: assert property (@(posedge clk) disable iff (rst)
    char_out.valid && char_out.status_valid && char_out.status != ndsf_pkg::ST_OK
      |-> char_out.text_length == 8'd0)
    else $error("error status carries a text length");

  a_char_no_status: assert property (@(posedge clk) disable iff (rst)
    char_out.valid && char_out.char_valid |-> !char_out.status_valid)
    else $error("character result flagged as status");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !char_out.valid)
    else $error("result valid right after reset");

endmodule
